// File: design/swmt_pkg.sv
// shared types and constants for the sliding window mode tracker
package swmt_pkg;

    // default configuration
    localparam int VALUE_BITS_DEF = 12;
    localparam int MAX_COUNT_DEF  = 4096;

    // mode field codes
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // operations of the shared increment / decrement unit
    typedef enum logic {
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    // table access strobes from the sequencer
    typedef struct packed {
        logic vc_re;
        logic vc_we;
        logic pop_re;
        logic pop_we;
    } tbl_cmd_t;

endpackage

// File: design/swmt_alu.sv
// shared increment / decrement unit with zero detect
module swmt_alu
    import swmt_pkg::*;
#(
    parameter int W = 14
)
(
    input  logic [W-1:0] a,
    input  alu_op_t      op,
    output logic [W-1:0] y,
    output logic         y_zero
);

    always_comb
    begin
        case (op)
            ALU_INC: y = a + W'(1);
            ALU_DEC: y = a - W'(1);
            default: y = a;
        endcase
    end

    assign y_zero = (y == '0);

endmodule

// File: design/swmt_tables.sv
// count and population tables with the clearing sweep after reset
module swmt_tables
    import swmt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_COUNT  = MAX_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tbl_cmd_t                       cmd,
    input  logic [VALUE_BITS-1:0]          vc_addr,
    input  logic [$clog2(MAX_COUNT+1)-1:0] vc_wdata,
    output logic [$clog2(MAX_COUNT+1)-1:0] vc_rdata,
    input  logic [$clog2(MAX_COUNT+1)-1:0] pop_raddr,
    input  logic [$clog2(MAX_COUNT+1)-1:0] pop_waddr,
    input  logic [VALUE_BITS:0]            pop_wdata,
    output logic [VALUE_BITS:0]            pop_rdata,
    output logic                           busy
);

    localparam int NV     = 1 << VALUE_BITS;
    localparam int NP     = MAX_COUNT + 1;
    localparam int CNT_W  = $clog2(MAX_COUNT + 1);
    localparam int POP_W  = VALUE_BITS + 1;
    localparam int CLR_N  = (NV > NP) ? NV : NP;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
    localparam logic [CLR_W:0]   NV_EXT   = (CLR_W + 1)'(NV);
    localparam logic [CLR_W:0]   NP_EXT   = (CLR_W + 1)'(NP);

    logic [CNT_W-1:0] vc_mem  [NV];
    logic [POP_W-1:0] pop_mem [NP];

    logic [CLR_W-1:0] clr_cnt_reg;
    logic [CLR_W-1:0] clr_cnt_next;
    logic             busy_reg;
    logic             busy_next;

    logic                  vc_we_i;
    logic [VALUE_BITS-1:0] vc_waddr_i;
    logic [CNT_W-1:0]      vc_wdata_i;
    logic                  pop_we_i;
    logic [CNT_W-1:0]      pop_waddr_i;
    logic [POP_W-1:0]      pop_wdata_i;

    // sweep counter
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            if (clr_cnt_reg == CLR_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    // write port muxing: sweep has priority while busy
    always_comb
    begin
        if (busy_reg)
        begin
            vc_we_i     = ({1'b0, clr_cnt_reg} < NV_EXT);
            vc_waddr_i  = clr_cnt_reg[VALUE_BITS-1:0];
            vc_wdata_i  = '0;
            pop_we_i    = ({1'b0, clr_cnt_reg} < NP_EXT);
            pop_waddr_i = clr_cnt_reg[CNT_W-1:0];
            pop_wdata_i = '0;
        end
        else
        begin
            vc_we_i     = cmd.vc_we;
            vc_waddr_i  = vc_addr;
            vc_wdata_i  = vc_wdata;
            pop_we_i    = cmd.pop_we;
            pop_waddr_i = pop_waddr;
            pop_wdata_i = pop_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vc_we_i)
        begin
            vc_mem[vc_waddr_i] <= vc_wdata_i;
        end
        if (cmd.vc_re)
        begin
            vc_rdata <= vc_mem[vc_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_we_i)
        begin
            pop_mem[pop_waddr_i] <= pop_wdata_i;
        end
        if (cmd.pop_re)
        begin
            pop_rdata <= pop_mem[pop_raddr];
        end
    end

    assign busy = busy_reg;

endmodule

// File: design/sliding_window_mode_tracker.sv
// top level of the sliding window mode tracker: sequencer, output register, assertions
// Keeps a multiset of values and returns, for every input transaction, the highest
// multiplicity of any value after that step together with a rejected flag. mode 0 adds
// one occurrence of item_value, mode 1 removes one; removing an absent value or adding
// past MAX_COUNT changes nothing and sets rejected. An empty set reports 0. After reset
// both tables are swept to zero one entry per cycle over max(2^VALUE_BITS, MAX_COUNT+1)
// entries (4097 at the defaults), and in_stall stays high until the sweep is done. Each
// accepted transaction then walks the sequencer states S_CNT, S_DEC, S_INC and S_DONE, where
// its result is loaded into the output register (a rejected one goes from S_CNT straight to
// S_DONE), and in_stall stays high until the sequencer is back in S_IDLE, so no new item is
// taken before the last one has left S_DONE. The sequencer walks each update through the
// count table, then the population entry of the old count, then that of the new count, all
// through one shared increment / decrement unit. The output register lets the next
// transaction be accepted while the previous result waits on out_stall.
module sliding_window_mode_tracker
    import swmt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_COUNT  = MAX_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [VALUE_BITS-1:0]          item_value,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [$clog2(MAX_COUNT+1)-1:0] max_count,
    output logic                           rejected
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    localparam int POP_W = VALUE_BITS + 1;
    localparam int ALU_W = (CNT_W > POP_W) ? CNT_W : POP_W;
    localparam logic [CNT_W-1:0] MAX_CNT_V = CNT_W'(MAX_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_DEC,
        S_INC,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  mode_reg, mode_next;
    logic [VALUE_BITS-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]      old_cnt_reg, old_cnt_next;
    logic [CNT_W-1:0]      new_cnt_reg, new_cnt_next;
    logic                  rej_reg, rej_next;
    logic [CNT_W-1:0]      max_reg, max_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]      out_max_reg, out_max_next;
    logic                  out_rej_reg, out_rej_next;

    // table interface
    tbl_cmd_t              tbl_cmd;
    logic [VALUE_BITS-1:0] vc_addr;
    logic [CNT_W-1:0]      vc_wdata;
    logic [CNT_W-1:0]      vc_rdata;
    logic [CNT_W-1:0]      pop_raddr;
    logic [CNT_W-1:0]      pop_waddr;
    logic [POP_W-1:0]      pop_wdata;
    logic [POP_W-1:0]      pop_rdata;
    logic                  tbl_busy;

    // shared unit
    logic [ALU_W-1:0]      alu_a;
    alu_op_t               alu_op;
    logic [ALU_W-1:0]      alu_y;
    logic                  alu_y_zero;

    logic                  in_take;
    logic                  cnt_rej;

    swmt_tables #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_COUNT  (MAX_COUNT)
    ) u_tables (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (tbl_cmd),
        .vc_addr   (vc_addr),
        .vc_wdata  (vc_wdata),
        .vc_rdata  (vc_rdata),
        .pop_raddr (pop_raddr),
        .pop_waddr (pop_waddr),
        .pop_wdata (pop_wdata),
        .pop_rdata (pop_rdata),
        .busy      (tbl_busy)
    );

    swmt_alu #(
        .W (ALU_W)
    ) u_alu (
        .a      (alu_a),
        .op     (alu_op),
        .y      (alu_y),
        .y_zero (alu_y_zero)
    );

    // a transaction is only taken in idle once the sweep has finished
    assign in_stall = (state_reg != S_IDLE) || tbl_busy;
    assign in_take  = in_valid && !in_stall;

    // refusal test on the count read back from the table
    assign cnt_rej = (mode_reg == MODE_ADD) ? (vc_rdata == MAX_CNT_V) : (vc_rdata == '0);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        old_cnt_next   = old_cnt_reg;
        new_cnt_next   = new_cnt_reg;
        rej_next       = rej_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg;
        out_max_next   = out_max_reg;
        out_rej_next   = out_rej_reg;

        tbl_cmd   = '0;
        vc_addr   = idx_reg;
        vc_wdata  = new_cnt_reg;
        pop_raddr = old_cnt_reg;
        pop_waddr = old_cnt_reg;
        pop_wdata = alu_y[POP_W-1:0];
        alu_a     = ALU_W'(pop_rdata);
        alu_op    = ALU_DEC;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // launch the count read straight from the input port
                if (in_take)
                begin
                    tbl_cmd.vc_re = 1'b1;
                    vc_addr       = item_value;
                    mode_next     = mode;
                    idx_next      = item_value;
                    state_next    = S_CNT;
                end
            end

            S_CNT:
            begin
                // new count through the shared unit, write it back, fetch old population
                alu_a  = ALU_W'(vc_rdata);
                alu_op = (mode_reg == MODE_REMOVE) ? ALU_DEC : ALU_INC;
                if (cnt_rej)
                begin
                    rej_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rej_next       = 1'b0;
                    old_cnt_next   = vc_rdata;
                    new_cnt_next   = alu_y[CNT_W-1:0];
                    tbl_cmd.vc_we  = 1'b1;
                    vc_wdata       = alu_y[CNT_W-1:0];
                    tbl_cmd.pop_re = 1'b1;
                    pop_raddr      = vc_rdata;
                    state_next     = S_DEC;
                end
            end

            S_DEC:
            begin
                // one fewer value at the old count, fetch population of the new count
                alu_a          = ALU_W'(pop_rdata);
                alu_op         = ALU_DEC;
                tbl_cmd.pop_we = (old_cnt_reg != '0);
                pop_waddr      = old_cnt_reg;
                pop_wdata      = alu_y[POP_W-1:0];
                tbl_cmd.pop_re = (new_cnt_reg != '0);
                pop_raddr      = new_cnt_reg;
                if (mode_reg == MODE_ADD)
                begin
                    if (new_cnt_reg > max_reg)
                    begin
                        max_next = new_cnt_reg;
                    end
                end
                else if ((old_cnt_reg == max_reg) && alu_y_zero)
                begin
                    // nobody left at the old maximum
                    max_next = new_cnt_reg;
                end
                state_next = S_INC;
            end

            S_INC:
            begin
                // one more value at the new count
                alu_a          = ALU_W'(pop_rdata);
                alu_op         = ALU_INC;
                tbl_cmd.pop_we = (new_cnt_reg != '0);
                pop_waddr      = new_cnt_reg;
                pop_wdata      = alu_y[POP_W-1:0];
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_max_next   = max_reg;
                    out_rej_next   = rej_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_ADD;
            idx_reg       <= '0;
            old_cnt_reg   <= '0;
            new_cnt_reg   <= '0;
            rej_reg       <= 1'b0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_max_reg   <= '0;
            out_rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            old_cnt_reg   <= old_cnt_next;
            new_cnt_reg   <= new_cnt_next;
            rej_reg       <= rej_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
            out_max_reg   <= out_max_next;
            out_rej_reg   <= out_rej_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign max_count = out_max_reg;
    assign rejected  = out_rej_reg;

    // an accepted transaction always starts with the count read
    a_take_to_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_CNT))
        else $error("accepted transaction did not enter the count stage");

    // the running maximum never exceeds the count limit
    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (max_reg <= MAX_CNT_V))
        else $error("running maximum beyond count limit");

    // the running maximum only moves out of the population decrement stage
    a_max_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(max_reg) |-> ($past(state_reg) == S_DEC))
        else $error("running maximum changed outside its update stage");

    // the sequencer is idle when the clearing sweep ends
    a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(tbl_busy) |-> (state_reg == S_IDLE))
        else $error("sequencer active during table sweep");

endmodule

// File: tb/peak_count_checker.sv
`timescale 1ns / 100ps
// channel monitor: predicts the highest multiplicity per transaction and checks each result
module peak_count_checker
    import swmt_pkg::*;
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 mode,
    input  logic [VALUE_BITS_DEF-1:0]            item_value,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [$clog2(MAX_COUNT_DEF+1)-1:0]   max_count,
    input  logic                                 rejected,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked
);

    localparam int CNT_W      = $clog2(MAX_COUNT_DEF + 1);
    localparam int NUM_VALUES = 1 << VALUE_BITS_DEF;
    localparam int MAX_SHOWN  = 40;

    typedef struct packed {
        logic [CNT_W-1:0] max_count;
        logic             rejected;
    } peak_result_t;

    // multiplicity of each value, number of values at each multiplicity, current peak
    logic [CNT_W-1:0] value_count [0:NUM_VALUES-1];
    logic [CNT_W-1:0] holders_at  [0:MAX_COUNT_DEF];
    logic [CNT_W-1:0] peak;

    peak_result_t expected_peaks [$];

    initial
    begin
        for (int i = 0; i < NUM_VALUES; i++)
            value_count[i] = '0;
        for (int i = 0; i <= MAX_COUNT_DEF; i++)
            holders_at[i] = '0;
        peak       = '0;
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    task automatic flag_error(input string msg);
        begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display("%0t: %s", $time, msg);
            else if (fail_count == MAX_SHOWN + 1)
                $display("%0t: further mismatches counted but not shown", $time);
        end
    endtask

    // one add or remove applied to the multiset
    task automatic apply_to_multiset(input logic op, input logic [VALUE_BITS_DEF-1:0] v,
                                     output peak_result_t res);
        logic [CNT_W-1:0] old_n;
        logic [CNT_W-1:0] new_n;
        begin
            old_n        = value_count[v];
            res.rejected = 1'b0;
            if (op == MODE_ADD)
            begin
                if (old_n >= MAX_COUNT_DEF)
                    res.rejected = 1'b1;
                else
                begin
                    new_n          = old_n + 1'b1;
                    value_count[v] = new_n;
                    if (old_n != 0)
                        holders_at[old_n] = holders_at[old_n] - 1'b1;
                    holders_at[new_n] = holders_at[new_n] + 1'b1;
                    if (new_n > peak)
                        peak = new_n;
                end
            end
            else
            begin
                if (old_n == 0)
                    res.rejected = 1'b1;
                else
                begin
                    new_n             = old_n - 1'b1;
                    value_count[v]    = new_n;
                    holders_at[old_n] = holders_at[old_n] - 1'b1;
                    if (new_n != 0)
                        holders_at[new_n] = holders_at[new_n] + 1'b1;
                    // peak only falls when nobody is left at the old peak
                    if (old_n == peak && holders_at[old_n] == 0)
                        peak = new_n;
                end
            end
            res.max_count = peak;
        end
    endtask

    always @(posedge clk)
    begin
        peak_result_t want;
        peak_result_t fresh;
        if (rst_n)
        begin
            // result side first so a result never matches its own transaction
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_peaks.size() == 0)
                    flag_error($sformatf(
                        "result with no transaction waiting: max_count %0d rejected %0b",
                        max_count, rejected));
                else
                begin
                    want = expected_peaks.pop_front();
                    if (max_count !== want.max_count)
                        flag_error($sformatf("max_count mismatch, expected %0d, actual %0d",
                                             want.max_count, max_count));
                    if (rejected !== want.rejected)
                        flag_error($sformatf("rejected mismatch, expected %0b, actual %0b",
                                             want.rejected, rejected));
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_to_multiset(mode, item_value, fresh);
                expected_peaks = {expected_peaks, fresh};
            end
        end
        pending <= expected_peaks.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// top of the mode tracker testbench: clock, reset, stimulus, back-pressure and verdict
module testbench;
    import swmt_pkg::*;

    localparam int CNT_W = $clog2(MAX_COUNT_DEF + 1);

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      mode;
    logic [VALUE_BITS_DEF-1:0] item_value;
    logic                      out_valid;
    logic                      out_stall;
    logic [CNT_W-1:0]          max_count;
    logic                      rejected;

    int fail_count;
    int pending;
    int checked;
    int sent;

    // set during stretches where neither side may idle
    logic no_idle;

    // values currently inside the sliding window, oldest first
    logic [VALUE_BITS_DEF-1:0] window_q [$];

    sliding_window_mode_tracker DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .max_count  (max_count),
        .rejected   (rejected)
    );

    // watches both channels, predicts and compares; only counts come back here
    peak_count_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .max_count  (max_count),
        .rejected   (rejected),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // generous cap: the slowest legal run is well under a tenth of this
    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d results still outstanding", $time, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // idle length for either side: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (no_idle || r < 55)
                idle_len = 0;
            else if (r < 92)
                idle_len = $urandom_range(1, 3);
            else
                idle_len = $urandom_range(8, 30);
        end
    endfunction

    // receiver back-pressure: stall bursts separated by short free runs
    initial
    begin
        int stall_len;
        out_stall <= 1'b0;
        forever
        begin
            stall_len = idle_len();
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // one input transaction, with an optional idle gap in front of it
    task automatic send_item(input logic op, input logic [VALUE_BITS_DEF-1:0] v);
        int gap;
        begin
            gap = idle_len();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid   <= 1'b1;
            mode       <= op;
            item_value <= v;
            do
                @(posedge clk);
            while (in_stall);
            sent++;
        end
    endtask

    // hold the sender until every outstanding result has come back
    task automatic settle_all();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        int r;
        int window_len;
        int pool;
        logic [VALUE_BITS_DEF-1:0] base;
        logic [VALUE_BITS_DEF-1:0] v;

        sent       = 0;
        no_idle    = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        mode       <= MODE_ADD;
        item_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty set, extreme values, peak falling only when its level empties
        send_item(MODE_REMOVE, 12'h000);   // remove from an empty set
        send_item(MODE_ADD,    12'h000);
        send_item(MODE_ADD,    12'hFFF);
        send_item(MODE_ADD,    12'hFFF);
        send_item(MODE_REMOVE, 12'h000);
        send_item(MODE_REMOVE, 12'h000);   // now absent
        send_item(MODE_REMOVE, 12'hFFF);
        send_item(MODE_REMOVE, 12'hFFF);   // back to empty
        send_item(MODE_ADD,    12'hAAA);
        send_item(MODE_ADD,    12'h555);
        send_item(MODE_ADD,    12'hAAA);
        send_item(MODE_ADD,    12'h555);
        send_item(MODE_REMOVE, 12'hAAA);   // 555 still holds the peak
        send_item(MODE_REMOVE, 12'h555);
        send_item(MODE_REMOVE, 12'hAAA);
        send_item(MODE_REMOVE, 12'h555);
        send_item(MODE_REMOVE, 12'hAAA);   // absent again

        // one value driven to a deep peak and back, with no idling on either side
        no_idle = 1'b1;
        repeat (40) send_item(MODE_ADD, 12'h7FF);
        send_item(MODE_ADD, 12'h123);
        repeat (40) send_item(MODE_REMOVE, 12'h7FF);
        send_item(MODE_REMOVE, 12'h7FF);
        send_item(MODE_REMOVE, 12'h123);
        no_idle = 1'b0;
        settle_all();

        // random sliding-window traffic, each phase with its own window and value pool
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       begin window_len = 6;  pool = 3;  end
                1:       begin window_len = 24; pool = 1;  end
                2:       begin window_len = 64; pool = 16; end
                3:       begin window_len = 1;  pool = 2;  end
                default: begin window_len = 12; pool = 8;  end
            endcase
            base    = VALUE_BITS_DEF'($urandom);
            no_idle = (ph == 1);
            repeat (80)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    // well-formed: either the oldest value leaves or a new one enters
                    if (window_q.size() >= window_len ||
                        (window_q.size() > 0 && $urandom_range(0, 3) == 0))
                        send_item(MODE_REMOVE, window_q.pop_front());
                    else
                    begin
                        v = base ^ VALUE_BITS_DEF'($urandom_range(0, pool - 1));
                        window_q = {window_q, v};
                        send_item(MODE_ADD, v);
                    end
                end
                else
                    // noise: any value, either direction, may break the window
                    send_item($urandom_range(0, 1) ? MODE_REMOVE : MODE_ADD,
                              VALUE_BITS_DEF'($urandom));
            end
            if (ph == 2)
                settle_all();
        end

        settle_all();
        repeat (20) @(posedge clk);

        $display("%0d transactions sent, %0d results checked", sent, checked);
        $display("covered empty set, absent removes, a deep single-value peak and five window phases");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
